// File: rtl/hbs_pkg.sv
// Shared types and constants for the height-map bilinear sampler.
// No dependencies; imported by every module of the block.
package hbs_pkg;

  // Field widths of the item channels
  localparam int OP_W       = 2;
  localparam int IDX_W      = 16;
  localparam int SAMPLE_W   = 8;
  localparam int POS_W      = 17;
  localparam int CELL_W     = 16;
  localparam int HEIGHT_W   = 18;
  localparam int SCALE_W    = 16;
  localparam int DIMCFG_W   = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // scale_z is Q8.8
  localparam int SCALE_SHIFT = 8;

  // Opcodes
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_COMMIT = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z   = 2'd2;

  localparam logic [DIMCFG_W-1:0] DIM_RESET   = 9'd2;
  localparam logic [SCALE_W-1:0]  SCALE_RESET = 16'd256;

  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 18'sh1FFFF;
  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 18'sh20000;

  // Per-item control bits that travel down the pipeline
  typedef struct packed {
    logic is_write;
    logic is_query;
    logic was_loaded;
    logic on_terrain;
  } hbs_tag_t;

endpackage

// File: rtl/heightmap_bilinear_sampler_core.sv
// Top level of the height-map bilinear sampler: config registers, pipeline, output skid.
// Depends on hbs_pkg, hbs_front, hbs_store, hbs_lerp.
//
// Usage:
//   in_*  : one item per handshake. in_tuser holds the opcode (write cell, commit, query).
//           A write stores (sample * scale_z) >> 8 at cell_index; a commit marks the grid
//           loaded; a query returns the bilinear height at (x_pos, z_pos), signed Q17.0.
//   out_* : exactly one item per input item, in input order.
//   cfg_* : write-only registers (map_width, map_depth, scale_z); write them only while
//           no item is in flight. Indexes past the list are ignored.
// Timing: seven register stages (decode/tile, address multiply, grid read, x lerp
//   multiplies, x lerp truncate and add, z lerp multiply, truncate/saturate). One item
//   per cycle is sustained while out_tready stays high, set by the single read of four
//   corners per cycle from two grid copies, each with two read ports.
// Reset: clears pipeline valid bits, the loaded flag and the config registers
//   (width 2, depth 2, scale 1.0). The grid itself is not cleared; a query must only
//   touch cells that were written.
// Stall: a one-item skid register catches the last stage when out_tready drops;
//   in_tready is simply "skid empty", so the pipeline freezes in the following cycle and
//   nothing is lost or repeated.
module heightmap_bilinear_sampler_core #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] cell_index, [23:16] sample, [40:24] x_pos, [57:41] z_pos, [63:58] zero
  input  logic [63:0]                        in_tdata,
  // [1:0] opcode
  input  logic [hbs_pkg::OP_W-1:0]           in_tuser,
  // result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [17:0] height_out, [18] on_terrain, [19] was_loaded, [23:20] zero
  output logic [23:0]                        out_tdata,
  // configuration
  input  logic                               cfg_we,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import hbs_pkg::*;

  localparam int SAMPLE_LSB = IDX_W;
  localparam int X_LSB      = SAMPLE_LSB + SAMPLE_W;
  localparam int Z_LSB      = X_LSB + POS_W;

  logic [DIMCFG_W-1:0] map_width_r, map_depth_r;
  logic [SCALE_W-1:0]  scale_z_r;

  logic en;

  logic                    s2_valid;
  hbs_tag_t                s2_tag;
  logic [IDX_W-1:0]        s2_addr, s2_row_step;
  logic [CELL_W-1:0]       s2_wr_data;
  logic signed [POS_W-1:0] s2_fx, s2_fz;

  logic                    s3_valid;
  hbs_tag_t                s3_tag;
  logic [CELL_W-1:0]       s3_c00, s3_c01, s3_c10, s3_c11;
  logic signed [POS_W-1:0] s3_fx, s3_fz;

  logic                       s7_valid;
  hbs_tag_t                   s7_tag;
  logic signed [HEIGHT_W-1:0] s7_height;

  logic                       skid_v_r;
  hbs_tag_t                   skid_tag_r;
  logic signed [HEIGHT_W-1:0] skid_height_r;

  hbs_tag_t                   out_tag;
  logic signed [HEIGHT_W-1:0] out_height;

  // whole pipeline advances whenever the skid slot is free
  assign en        = !skid_v_r;
  assign in_tready = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r <= DIM_RESET;
      map_depth_r <= DIM_RESET;
      scale_z_r   <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAP_WIDTH: map_width_r <= cfg_wdata[DIMCFG_W-1:0];
        CFG_MAP_DEPTH: map_depth_r <= cfg_wdata[DIMCFG_W-1:0];
        CFG_SCALE_Z:   scale_z_r   <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  hbs_front #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_tvalid),
    .opcode      (in_tuser),
    .cell_index  (in_tdata[IDX_W-1:0]),
    .sample      (in_tdata[SAMPLE_LSB +: SAMPLE_W]),
    .x_pos       ($signed(in_tdata[X_LSB +: POS_W])),
    .z_pos       ($signed(in_tdata[Z_LSB +: POS_W])),
    .map_width   (map_width_r),
    .map_depth   (map_depth_r),
    .scale_z     (scale_z_r),
    .s2_valid    (s2_valid),
    .s2_tag      (s2_tag),
    .s2_addr     (s2_addr),
    .s2_row_step (s2_row_step),
    .s2_wr_data  (s2_wr_data),
    .s2_fx       (s2_fx),
    .s2_fz       (s2_fz)
  );

  hbs_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .s2_valid    (s2_valid),
    .s2_tag      (s2_tag),
    .s2_addr     (s2_addr),
    .s2_row_step (s2_row_step),
    .s2_wr_data  (s2_wr_data),
    .s2_fx       (s2_fx),
    .s2_fz       (s2_fz),
    .s3_valid    (s3_valid),
    .s3_tag      (s3_tag),
    .s3_c00      (s3_c00),
    .s3_c01      (s3_c01),
    .s3_c10      (s3_c10),
    .s3_c11      (s3_c11),
    .s3_fx       (s3_fx),
    .s3_fz       (s3_fz)
  );

  hbs_lerp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .s3_valid  (s3_valid),
    .s3_tag    (s3_tag),
    .s3_c00    (s3_c00),
    .s3_c01    (s3_c01),
    .s3_c10    (s3_c10),
    .s3_c11    (s3_c11),
    .s3_fx     (s3_fx),
    .s3_fz     (s3_fz),
    .s7_valid  (s7_valid),
    .s7_tag    (s7_tag),
    .s7_height (s7_height)
  );

  // Skid: fills when the last stage holds an item the receiver did not take;
  // drains first once the receiver is ready again.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (s7_valid && !out_tready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_tag_r    <= s7_tag;
      skid_height_r <= s7_height;
    end
  end

  always_comb begin
    out_tag    = skid_v_r ? skid_tag_r : s7_tag;
    out_height = skid_v_r ? skid_height_r : s7_height;
  end

  assign out_tvalid = skid_v_r || s7_valid;
  assign out_tdata  = {4'b0000, out_tag.was_loaded, out_tag.on_terrain, out_height};

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(s7_valid && !out_tready))
    else $error("skid filled without a stalled result");

  a_pipe_frozen_while_skid: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |=> $stable(s7_valid) && $stable(s7_height))
    else $error("last stage moved while skid was full");

endmodule

// File: rtl/hbs_front.sv
// Front end: decode, sample scaling, tile search and cell address (stages 1-2).
// Depends on hbs_pkg.
module hbs_front #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [hbs_pkg::OP_W-1:0]         opcode,
  input  logic [hbs_pkg::IDX_W-1:0]        cell_index,
  input  logic [hbs_pkg::SAMPLE_W-1:0]     sample,
  input  logic signed [hbs_pkg::POS_W-1:0] x_pos,
  input  logic signed [hbs_pkg::POS_W-1:0] z_pos,
  input  logic [hbs_pkg::DIMCFG_W-1:0]     map_width,
  input  logic [hbs_pkg::DIMCFG_W-1:0]     map_depth,
  input  logic [hbs_pkg::SCALE_W-1:0]      scale_z,
  output logic                             s2_valid,
  output hbs_pkg::hbs_tag_t                s2_tag,
  output logic [hbs_pkg::IDX_W-1:0]        s2_addr,
  output logic [hbs_pkg::IDX_W-1:0]        s2_row_step,
  output logic [hbs_pkg::CELL_W-1:0]       s2_wr_data,
  output logic signed [hbs_pkg::POS_W-1:0] s2_fx,
  output logic signed [hbs_pkg::POS_W-1:0] s2_fz
);
  import hbs_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = (DIM_W > DIMCFG_W) ? DIM_W : DIMCFG_W;
  localparam int PW     = POS_W + DIM_W + FRAC_BITS + 1;
  localparam int AW     = (2 * DIM_W + 1 > IDX_W) ? 2 * DIM_W + 1 : IDX_W;
  localparam int PROD_W = SAMPLE_W + SCALE_W;

  // Dimension clamped to 2..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIMCFG_W-1:0] d);
    logic [CMP_W-1:0] dz;
    dz = CMP_W'(d);
    if (dz < CMP_W'(2)) eff_dim = DIM_W'(2);
    else if (dz > CMP_W'(MAX_DIM)) eff_dim = DIM_W'(MAX_DIM);
    else eff_dim = DIM_W'(dz);
  endfunction

  // floor(pos), clamped to 0..dim-2
  function automatic logic [DIM_W-1:0] tile_of(input logic signed [POS_W-1:0] pos,
                                               input logic [DIM_W-1:0] dim);
    logic signed [PW-1:0] t;
    logic signed [PW-1:0] lim;
    t   = PW'(pos) >>> FRAC_BITS;
    lim = $signed(PW'(dim)) - $signed(PW'(2));
    if (t < 0) tile_of = '0;
    else if (t > lim) tile_of = DIM_W'(lim);
    else tile_of = DIM_W'(t);
  endfunction

  logic                 loaded_r;
  logic                 accept;
  logic [DIM_W-1:0]     w_eff, d_eff, tx, tz;
  logic signed [PW-1:0] fx_w, fz_w, x_lim, z_lim;
  logic                 on_grid;
  logic [PROD_W-1:0]    prod;
  hbs_tag_t             tag_nxt;
  logic [AW-1:0]        i0_full;

  // stage 1 registers
  logic                    s1_valid_r;
  hbs_tag_t                s1_tag_r;
  logic [IDX_W-1:0]        s1_cell_r;
  logic [CELL_W-1:0]       s1_wr_r;
  logic [DIM_W-1:0]        s1_tx_r, s1_tz_r, s1_w_r;
  logic signed [POS_W-1:0] s1_fx_r, s1_fz_r;

  // stage 2 registers
  logic                    s2_valid_r;
  hbs_tag_t                s2_tag_r;
  logic [IDX_W-1:0]        s2_addr_r, s2_row_step_r;
  logic [CELL_W-1:0]       s2_wr_r;
  logic signed [POS_W-1:0] s2_fx_r, s2_fz_r;

  always_comb begin
    accept  = in_valid && en;
    w_eff   = eff_dim(map_width);
    d_eff   = eff_dim(map_depth);
    tx      = tile_of(x_pos, w_eff);
    tz      = tile_of(z_pos, d_eff);
    fx_w    = PW'(x_pos) - $signed(PW'(tx) << FRAC_BITS);
    fz_w    = PW'(z_pos) - $signed(PW'(tz) << FRAC_BITS);
    x_lim   = $signed(PW'(w_eff - DIM_W'(1)) << FRAC_BITS);
    z_lim   = $signed(PW'(d_eff - DIM_W'(1)) << FRAC_BITS);
    on_grid = (x_pos >= 0) && (z_pos >= 0) && (PW'(x_pos) < x_lim) && (PW'(z_pos) < z_lim);
    prod    = PROD_W'(sample) * PROD_W'(scale_z);

    tag_nxt.is_write   = (opcode == OP_WRITE);
    tag_nxt.is_query   = (opcode == OP_QUERY);
    tag_nxt.was_loaded = loaded_r;
    tag_nxt.on_terrain = (opcode == OP_QUERY) && on_grid;

    i0_full = AW'(s1_tz_r) * AW'(s1_w_r) + AW'(s1_tx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r   <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (accept && opcode == OP_COMMIT) begin
        loaded_r <= 1'b1;
      end
      if (en) begin
        s1_valid_r <= accept;
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag_r  <= tag_nxt;
      s1_cell_r <= cell_index;
      s1_wr_r   <= prod[SCALE_SHIFT +: CELL_W];
      s1_tx_r   <= tx;
      s1_tz_r   <= tz;
      s1_w_r    <= w_eff;
      s1_fx_r   <= fx_w[POS_W-1:0];
      s1_fz_r   <= fz_w[POS_W-1:0];

      s2_tag_r      <= s1_tag_r;
      s2_addr_r     <= s1_tag_r.is_write ? s1_cell_r : i0_full[IDX_W-1:0];
      s2_row_step_r <= IDX_W'(s1_w_r);
      s2_wr_r       <= s1_wr_r;
      s2_fx_r       <= s1_fx_r;
      s2_fz_r       <= s1_fz_r;
    end
  end

  assign s2_valid    = s2_valid_r;
  assign s2_tag      = s2_tag_r;
  assign s2_addr     = s2_addr_r;
  assign s2_row_step = s2_row_step_r;
  assign s2_wr_data  = s2_wr_r;
  assign s2_fx       = s2_fx_r;
  assign s2_fz       = s2_fz_r;

  // once loaded, the grid stays loaded until reset
  a_loaded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(loaded_r))
    else $error("loaded flag dropped without reset");

endmodule

// File: rtl/hbs_store.sv
// Height grid storage: two copies of the grid, each read at two addresses (stage 3).
// Depends on hbs_pkg.
module hbs_store (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             s2_valid,
  input  hbs_pkg::hbs_tag_t                s2_tag,
  input  logic [hbs_pkg::IDX_W-1:0]        s2_addr,
  input  logic [hbs_pkg::IDX_W-1:0]        s2_row_step,
  input  logic [hbs_pkg::CELL_W-1:0]       s2_wr_data,
  input  logic signed [hbs_pkg::POS_W-1:0] s2_fx,
  input  logic signed [hbs_pkg::POS_W-1:0] s2_fz,
  output logic                             s3_valid,
  output hbs_pkg::hbs_tag_t                s3_tag,
  output logic [hbs_pkg::CELL_W-1:0]       s3_c00,
  output logic [hbs_pkg::CELL_W-1:0]       s3_c01,
  output logic [hbs_pkg::CELL_W-1:0]       s3_c10,
  output logic [hbs_pkg::CELL_W-1:0]       s3_c11,
  output logic signed [hbs_pkg::POS_W-1:0] s3_fx,
  output logic signed [hbs_pkg::POS_W-1:0] s3_fz
);
  import hbs_pkg::*;

  localparam int DEPTH = 1 << IDX_W;

  // bottom row copy and top row copy; every write goes to both
  logic [CELL_W-1:0] bank_lo [DEPTH];
  logic [CELL_W-1:0] bank_hi [DEPTH];

  logic [IDX_W-1:0] a01, a10, a11;
  logic             wr_en;

  logic                    s3_valid_r;
  hbs_tag_t                s3_tag_r;
  logic [CELL_W-1:0]       c00_r, c01_r, c10_r, c11_r;
  logic signed [POS_W-1:0] s3_fx_r, s3_fz_r;

  always_comb begin
    wr_en = en && s2_valid && s2_tag.is_write;
    a01   = s2_addr + IDX_W'(1);
    a10   = s2_addr + s2_row_step;
    a11   = a10 + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank_lo[s2_addr] <= s2_wr_data;
      bank_hi[s2_addr] <= s2_wr_data;
    end
    if (en) begin
      c00_r    <= bank_lo[s2_addr];
      c01_r    <= bank_lo[a01];
      c10_r    <= bank_hi[a10];
      c11_r    <= bank_hi[a11];
      s3_tag_r <= s2_tag;
      s3_fx_r  <= s2_fx;
      s3_fz_r  <= s2_fz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid;
    end
  end

  assign s3_valid = s3_valid_r;
  assign s3_tag   = s3_tag_r;
  assign s3_c00   = c00_r;
  assign s3_c01   = c01_r;
  assign s3_c10   = c10_r;
  assign s3_c11   = c11_r;
  assign s3_fx    = s3_fx_r;
  assign s3_fz    = s3_fz_r;

endmodule

// File: rtl/hbs_lerp.sv
// Bilinear datapath: x lerps, z lerp, saturation (stages 4-7).
// Depends on hbs_pkg.
module hbs_lerp #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                s3_valid,
  input  hbs_pkg::hbs_tag_t                   s3_tag,
  input  logic [hbs_pkg::CELL_W-1:0]          s3_c00,
  input  logic [hbs_pkg::CELL_W-1:0]          s3_c01,
  input  logic [hbs_pkg::CELL_W-1:0]          s3_c10,
  input  logic [hbs_pkg::CELL_W-1:0]          s3_c11,
  input  logic signed [hbs_pkg::POS_W-1:0]    s3_fx,
  input  logic signed [hbs_pkg::POS_W-1:0]    s3_fz,
  output logic                                s7_valid,
  output hbs_pkg::hbs_tag_t                   s7_tag,
  output logic signed [hbs_pkg::HEIGHT_W-1:0] s7_height
);
  import hbs_pkg::*;

  localparam int DW1 = CELL_W + 1;
  localparam int P1W = DW1 + POS_W;
  // |weight| <= 2^16, so one lerp stays within 2^(32-FRAC) plus a cell
  localparam int HW  = 2 * CELL_W + 2 - FRAC_BITS;
  localparam int DW2 = HW + 1;
  localparam int P2W = DW2 + POS_W;
  localparam int SW  = P2W + 1;
  localparam logic signed [P1W-1:0] BIAS1 = P1W'((1 << FRAC_BITS) - 1);
  localparam logic signed [P2W-1:0] BIAS2 = P2W'((1 << FRAC_BITS) - 1);

  // stage 4
  logic signed [DW1-1:0]   d_lo, d_hi;
  logic signed [P1W-1:0]   p_lo, p_hi;
  logic                    s4_valid_r;
  hbs_tag_t                s4_tag_r;
  logic signed [P1W-1:0]   s4_p_lo_r, s4_p_hi_r;
  logic [CELL_W-1:0]       s4_a_lo_r, s4_a_hi_r;
  logic signed [POS_W-1:0] s4_fz_r;

  // stage 5
  logic signed [P1W-1:0]   bias_lo, bias_hi, q_lo, q_hi;
  logic signed [HW-1:0]    hb, ht;
  logic                    s5_valid_r;
  hbs_tag_t                s5_tag_r;
  logic signed [HW-1:0]    s5_hb_r, s5_ht_r;
  logic signed [POS_W-1:0] s5_fz_r;

  // stage 6
  logic signed [DW2-1:0]   d_z;
  logic signed [P2W-1:0]   p_z;
  logic                    s6_valid_r;
  hbs_tag_t                s6_tag_r;
  logic signed [P2W-1:0]   s6_p_r;
  logic signed [HW-1:0]    s6_hb_r;

  // stage 7
  logic signed [P2W-1:0]      bias_z, q_z;
  logic signed [SW-1:0]       h_full;
  logic signed [HEIGHT_W-1:0] h_sat;
  logic                       s7_valid_r;
  hbs_tag_t                   s7_tag_r;
  logic signed [HEIGHT_W-1:0] s7_height_r;

  always_comb begin
    d_lo = $signed({1'b0, s3_c01}) - $signed({1'b0, s3_c00});
    d_hi = $signed({1'b0, s3_c11}) - $signed({1'b0, s3_c10});
    p_lo = d_lo * s3_fx;
    p_hi = d_hi * s3_fx;

    // truncating divide by 2^FRAC_BITS: bias negatives before the shift
    bias_lo = s4_p_lo_r[P1W-1] ? BIAS1 : P1W'(0);
    bias_hi = s4_p_hi_r[P1W-1] ? BIAS1 : P1W'(0);
    q_lo    = (s4_p_lo_r + bias_lo) >>> FRAC_BITS;
    q_hi    = (s4_p_hi_r + bias_hi) >>> FRAC_BITS;
    hb      = HW'($signed({1'b0, s4_a_lo_r})) + HW'(q_lo);
    ht      = HW'($signed({1'b0, s4_a_hi_r})) + HW'(q_hi);

    d_z = DW2'(s5_ht_r) - DW2'(s5_hb_r);
    p_z = d_z * s5_fz_r;

    bias_z = s6_p_r[P2W-1] ? BIAS2 : P2W'(0);
    q_z    = (s6_p_r + bias_z) >>> FRAC_BITS;
    h_full = SW'(s6_hb_r) + SW'(q_z);
    if (h_full > HEIGHT_MAX) h_sat = HEIGHT_MAX;
    else if (h_full < HEIGHT_MIN) h_sat = HEIGHT_MIN;
    else h_sat = h_full[HEIGHT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_tag_r  <= s3_tag;
      s4_p_lo_r <= p_lo;
      s4_p_hi_r <= p_hi;
      s4_a_lo_r <= s3_c00;
      s4_a_hi_r <= s3_c10;
      s4_fz_r   <= s3_fz;

      s5_tag_r <= s4_tag_r;
      s5_hb_r  <= hb;
      s5_ht_r  <= ht;
      s5_fz_r  <= s4_fz_r;

      s6_tag_r <= s5_tag_r;
      s6_p_r   <= p_z;
      s6_hb_r  <= s5_hb_r;

      s7_tag_r    <= s6_tag_r;
      s7_height_r <= (s6_tag_r.is_query && s6_tag_r.was_loaded) ? h_sat : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
      s7_valid_r <= s6_valid_r;
    end
  end

  assign s7_valid  = s7_valid_r;
  assign s7_tag    = s7_tag_r;
  assign s7_height = s7_height_r;

  a_zero_unless_loaded_query: assert property (@(posedge clk) disable iff (!rst_n)
    s7_valid_r && !(s7_tag_r.is_query && s7_tag_r.was_loaded) |-> s7_height_r == '0)
    else $error("nonzero height on an item that is not a loaded query");

  a_on_terrain_query_only: assert property (@(posedge clk) disable iff (!rst_n)
    s7_valid_r && !s7_tag_r.is_query |-> !s7_tag_r.on_terrain)
    else $error("on_terrain set on a non-query item");

endmodule
